@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk once reset has been released.
`define EPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define EPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/epg_pkg.sv @@
`default_nettype none
package epg_pkg;

  localparam int unsigned PANEL_HEIGHT = 480;
  localparam int unsigned ROW_BYTES    = 100;
  localparam int unsigned LANES        = 8;

  localparam int unsigned COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int unsigned ROW_W = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int unsigned IDX_W = 19;

  // Texture index advance from one byte column to the next, kept to IDX_W bits.
  localparam logic [IDX_W-1:0] COL_STEP = IDX_W'((8 * PANEL_HEIGHT) % (1 << IDX_W));
  localparam logic [ROW_W-1:0] LAST_REV = ROW_W'(PANEL_HEIGHT - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_BYTES - 1);

  // Register indexes on the configuration port.
  localparam logic REG_GRAY_MODE = 1'b0;
  localparam logic REG_INVERT    = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic             frame_end;
  } pos_t;

  typedef struct packed {
    logic gray_mode;
    logic invert;
  } mode_t;

  // Gray level selected by {mono, high, low} plane bits.
  function automatic logic [7:0] gray_level(input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd0;
      3'd2:    v = 8'd170;
      3'd3:    v = 8'd85;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/epg_if.sv @@
`default_nettype none
interface epg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mono_byte;
  logic [7:0] low_gray_byte;
  logic [7:0] high_gray_byte;
  logic       frame_start;

  modport source (output valid, mono_byte, low_gray_byte, high_gray_byte, frame_start,
                  input ready);
  modport sink   (input valid, mono_byte, low_gray_byte, high_gray_byte, frame_start,
                  output ready);
endinterface

interface epg_out_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     gray_0;
  logic [7:0]                     gray_1;
  logic [7:0]                     gray_2;
  logic [7:0]                     gray_3;
  logic [7:0]                     gray_4;
  logic [7:0]                     gray_5;
  logic [7:0]                     gray_6;
  logic [7:0]                     gray_7;
  logic [epg_pkg::IDX_W-1:0]      first_index;
  logic                           frame_end;

  modport source (output valid, gray_0, gray_1, gray_2, gray_3, gray_4, gray_5, gray_6,
                  gray_7, first_index, frame_end, input ready);
  modport sink   (input valid, gray_0, gray_1, gray_2, gray_3, gray_4, gray_5, gray_6,
                  gray_7, first_index, frame_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/epg_lane.sv @@
`default_nettype none
module epg_lane (
  input  wire logic           mono_bit,
  input  wire logic           high_bit,
  input  wire logic           low_bit,
  input  wire epg_pkg::mode_t mode,
  output logic [7:0]          gray
);

  logic [7:0] level;

  always_comb begin
    if (mode.gray_mode) begin
      level = epg_pkg::gray_level({mono_bit, high_bit, low_bit});
    end else begin
      level = {8{mono_bit}};
    end
  end

  // 255 - v is a plain bitwise complement on eight bits.
  assign gray = mode.invert ? ~level : level;

endmodule
`default_nettype wire

@@ hw/rtl/epg_pos.sv @@
`default_nettype none
`include "assert_macros.svh"
module epg_pos (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic          frame_start,
  output epg_pkg::pos_t      pos
);

  logic [epg_pkg::COL_W-1:0] byte_column_r, byte_column_nxt;
  logic [epg_pkg::ROW_W-1:0] rev_row_r, rev_row_nxt;
  logic [epg_pkg::IDX_W-1:0] col_base_r, col_base_nxt;

  logic [epg_pkg::COL_W-1:0] cur_col;
  logic [epg_pkg::ROW_W-1:0] cur_rev;
  logic [epg_pkg::IDX_W-1:0] cur_base;
  logic                      last_col;
  logic                      last_row;

  // The row counter is held reversed (PANEL_HEIGHT-1-row), which is what the
  // texture index needs; the column term is kept as a running sum.
  always_comb begin
    cur_col  = frame_start ? '0 : byte_column_r;
    cur_rev  = frame_start ? epg_pkg::LAST_REV : rev_row_r;
    cur_base = frame_start ? '0 : col_base_r;
    last_col = (cur_col == epg_pkg::LAST_COL);
    last_row = (cur_rev == '0);

    pos.first_index = cur_base + epg_pkg::IDX_W'(cur_rev);
    pos.frame_end   = last_col && last_row;

    if (last_col) begin
      byte_column_nxt = '0;
      col_base_nxt    = '0;
      rev_row_nxt     = last_row ? epg_pkg::LAST_REV : cur_rev - 1'b1;
    end else begin
      byte_column_nxt = cur_col + 1'b1;
      col_base_nxt    = cur_base + epg_pkg::COL_STEP;
      rev_row_nxt     = cur_rev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= '0;
      rev_row_r     <= epg_pkg::LAST_REV;
      col_base_r    <= '0;
    end else if (advance) begin
      byte_column_r <= byte_column_nxt;
      rev_row_r     <= rev_row_nxt;
      col_base_r    <= col_base_nxt;
    end
  end

  `EPG_ASSERT(a_col_range, byte_column_r <= epg_pkg::LAST_COL, "byte column out of range")
  `EPG_ASSERT(a_row_range, rev_row_r <= epg_pkg::LAST_REV, "row counter out of range")
  `EPG_ASSERT(a_base_zero, byte_column_r == '0 |-> col_base_r == '0, "column base not cleared")
  `EPG_ASSERT(a_frame_wrap, advance && pos.frame_end |=> byte_column_r == '0 &&
              rev_row_r == epg_pkg::LAST_REV, "counters did not wrap at frame end")

endmodule
`default_nettype wire

@@ hw/rtl/eink_plane_to_rotated_gray_unit.sv @@
`default_nettype none
`include "assert_macros.svh"
// Unpacks one byte column of an e-ink frame per beat into eight gray pixel values plus
// the portrait texture index of the leftmost pixel (pixel k sits PANEL_HEIGHT*k further on).
// Each beat leaves the output register in the cycle after its acceptance, and a new beat is
// accepted every cycle while the result side keeps taking beats; the output register's
// handshake is the only thing that sets the rate. Eight pixel lanes work in parallel.
// Row and column counters follow the stream, restart on frame_start and wrap after the
// last byte of a frame, which is flagged by frame_end. Registers: gray_mode at 0x0, invert
// at 0x4; write them only while no beat is in flight.
module eink_plane_to_rotated_gray_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  epg_in_if.sink           in_bus,
  epg_out_if.source        out_bus,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  epg_pkg::mode_t mode_r;
  epg_pkg::pos_t  pos;
  logic           accept;
  logic           cfg_write;
  logic           out_valid_r;
  logic [7:0]     lane_gray [epg_pkg::LANES];
  logic [7:0]     gray_r    [epg_pkg::LANES];
  logic [epg_pkg::IDX_W-1:0] first_index_r;
  logic           frame_end_r;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_write) begin
      if (paddr[2] == epg_pkg::REG_GRAY_MODE) begin
        mode_r.gray_mode <= pwdata[0];
      end else begin
        mode_r.invert <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == epg_pkg::REG_GRAY_MODE) begin
      prdata = {31'd0, mode_r.gray_mode};
    end else begin
      prdata = {31'd0, mode_r.invert};
    end
  end

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;

  for (genvar k = 0; k < epg_pkg::LANES; k++) begin : g_lane
    epg_lane u_lane (
      .mono_bit (in_bus.mono_byte[epg_pkg::LANES-1-k]),
      .high_bit (in_bus.high_gray_byte[epg_pkg::LANES-1-k]),
      .low_bit  (in_bus.low_gray_byte[epg_pkg::LANES-1-k]),
      .mode     (mode_r),
      .gray     (lane_gray[k])
    );
  end

  epg_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .frame_start (in_bus.frame_start),
    .pos         (pos)
  );

  // Merge stage: the lanes' values and the position join in one output beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      out_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gray_r        <= lane_gray;
      first_index_r <= pos.first_index;
      frame_end_r   <= pos.frame_end;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.gray_0      = gray_r[0];
  assign out_bus.gray_1      = gray_r[1];
  assign out_bus.gray_2      = gray_r[2];
  assign out_bus.gray_3      = gray_r[3];
  assign out_bus.gray_4      = gray_r[4];
  assign out_bus.gray_5      = gray_r[5];
  assign out_bus.gray_6      = gray_r[6];
  assign out_bus.gray_7      = gray_r[7];
  assign out_bus.first_index = first_index_r;
  assign out_bus.frame_end   = frame_end_r;

  `EPG_ASSERT(a_no_overrun, out_valid_r && !out_bus.ready |-> !accept,
              "beat accepted while result is stalled")
  `EPG_ASSERT(a_accept_loads, accept |=> out_valid_r, "accepted beat not presented")
  `EPG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
`default_nettype wire
